FILE: rtl/core/skyl_pkg.sv
// shared types, codes and sizes for the skyline outline tracker
// no dependencies; used by every module under rtl/core
package skyl_pkg;

  localparam int H_W            = 16;
  localparam int X_W            = 16;
  localparam int MAX_ACTIVE_DEF = 64;

  // event kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_END   = 1'b1;

  // result status codes
  localparam logic [1:0] ST_CORNER  = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  // incoming edge event
  typedef struct packed {
    logic           kind;
    logic [X_W-1:0] pos_x;
    logic [H_W-1:0] height;
  } evt_t;

  // outgoing outline corner or status
  typedef struct packed {
    logic [X_W-1:0] corner_x;
    logic [H_W-1:0] corner_y;
    logic           last_of_run;
    logic [1:0]     status;
  } crn_t;

  // one entry of the sorted height chain
  typedef struct packed {
    logic           vld;
    logic [H_W-1:0] hgt;
  } cell_t;

  // command broadcast along the chain
  typedef struct packed {
    logic           ins;
    logic           del;
    logic [H_W-1:0] hgt;
  } cmd_t;

endpackage

FILE: rtl/core/skyl_cell.sv
// one cell of the descending height chain: holds a single active height
// depends on skyl_pkg
module skyl_cell (
  input  logic           clk,
  input  logic           rst,
  input  skyl_pkg::cmd_t  cmd,
  input  skyl_pkg::cell_t up,
  input  logic           up_keep,
  input  skyl_pkg::cell_t dn,
  output skyl_pkg::cell_t cur,
  output logic           keep,
  output logic           hit
);

  skyl_pkg::cell_t cur_next;
  logic            shift;

  // local compares against the broadcast height
  always_comb begin
    keep  = cur.vld && (cur.hgt >= cmd.hgt);
    shift = !cur.vld || (cur.hgt <= cmd.hgt);
    hit   = cur.vld && (cur.hgt == cmd.hgt);
  end

  // insert shifts entries down below the slot, delete pulls them up
  always_comb begin
    cur_next = cur;
    if (cmd.ins && !keep) begin
      if (up_keep) begin
        cur_next.vld = 1'b1;
        cur_next.hgt = cmd.hgt;
      end else begin
        cur_next = up;
      end
    end else if (cmd.del && shift) begin
      cur_next = dn;
    end
  end

  // only the valid bit is cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.vld <= 1'b0;
    end else begin
      cur <= cur_next;
    end
  end

endmodule

FILE: rtl/core/skyl_res_q.sv
// two-entry result queue between the chain update and the corner channel
// depends on skyl_pkg
module skyl_res_q (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  logic [1:0]     load_cnt,
  input  skyl_pkg::crn_t load_a,
  input  skyl_pkg::crn_t load_b,
  output logic           crn_valid,
  input  logic           crn_ready,
  output skyl_pkg::crn_t crn,
  output logic [1:0]     level
);

  skyl_pkg::crn_t slot_b;
  logic           pop;

  assign pop       = crn_valid && crn_ready;
  assign crn_valid = (level != 2'd0);

  // fill level; a load only arrives while the queue is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 2'd0;
    end else if (load) begin
      level <= load_cnt;
    end else if (pop) begin
      level <= level - 2'd1;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (load) begin
      crn    <= load_a;
      slot_b <= load_b;
    end else if (pop) begin
      crn    <= slot_b;
    end
  end

endmodule

FILE: rtl/core/skyline_outline_tracker.sv
// top level of the skyline outline tracker: request capture, cell chain, results
// depends on skyl_pkg, skyl_cell, skyl_res_q
//
//   channel  signals                     payload          direction
//   evt      evt_valid / evt_ready / evt skyl_pkg::evt_t  edge events in
//   crn      crn_valid / crn_ready / crn skyl_pkg::crn_t  corners / status out
//
// an event is handled as a capture, then one update of the whole cell chain
// results (none, one or two) leave one per cycle from a two-entry queue while crn is not stalled
// the next event is taken once the queue is empty or its final result leaves
// reset clears every cell valid bit together; no clearing pass
// a stall on crn holds results in the queue and blocks new events
module skyline_outline_tracker #(
  parameter int MAX_ACTIVE = skyl_pkg::MAX_ACTIVE_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           evt_valid,
  output logic           evt_ready,
  input  skyl_pkg::evt_t evt,
  output logic           crn_valid,
  input  logic           crn_ready,
  output skyl_pkg::crn_t crn
);

  logic                       busy;
  skyl_pkg::evt_t             req;
  skyl_pkg::cmd_t             cmd;
  skyl_pkg::cell_t            row [MAX_ACTIVE];
  logic [MAX_ACTIVE-1:0]      keep_v;
  logic [MAX_ACTIVE-1:0]      hit_v;
  logic                       full;
  logic                       found;
  logic [skyl_pkg::H_W-1:0]   old_max;
  logic [skyl_pkg::H_W-1:0]   new_max;
  logic                       head_shift;
  logic [1:0]                 res_cnt;
  skyl_pkg::crn_t             res_a;
  skyl_pkg::crn_t             res_b;
  logic [1:0]                 level;

  // request capture
  assign evt_ready = !busy && ((level == 2'd0) || ((level == 2'd1) && crn_ready));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= evt_valid && evt_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && evt_ready) begin
      req <= evt;
    end
  end

  // chain status and command
  assign full  = row[MAX_ACTIVE-1].vld;
  assign found = |hit_v;

  always_comb begin
    cmd.hgt = req.height;
    cmd.ins = busy && (req.kind == skyl_pkg::KIND_START) && !full;
    cmd.del = busy && (req.kind == skyl_pkg::KIND_END) && found;
  end

  // row of cells, maximum at the head
  for (genvar i = 0; i < MAX_ACTIVE; i++) begin : g_cell
    skyl_pkg::cell_t up_c;
    skyl_pkg::cell_t dn_c;
    logic            up_k;
    if (i == 0) begin : g_head
      assign up_c = '0;
      assign up_k = 1'b1;
    end else begin : g_mid
      assign up_c = row[i-1];
      assign up_k = keep_v[i-1];
    end
    if (i == MAX_ACTIVE - 1) begin : g_tail
      assign dn_c = '0;
    end else begin : g_body
      assign dn_c = row[i+1];
    end
    skyl_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .up      (up_c),
      .up_keep (up_k),
      .dn      (dn_c),
      .cur     (row[i]),
      .keep    (keep_v[i]),
      .hit     (hit_v[i])
    );
  end

  // old and new maximum seen at the head of the chain
  always_comb begin
    old_max    = row[0].vld ? row[0].hgt : '0;
    head_shift = !row[0].vld || (row[0].hgt <= req.height);
    if (head_shift) begin
      new_max = row[1].vld ? row[1].hgt : '0;
    end else begin
      new_max = old_max;
    end
  end

  // result selection
  always_comb begin
    res_cnt = 2'd0;
    res_a   = '{corner_x: req.pos_x, corner_y: old_max, last_of_run: 1'b0,
                status: skyl_pkg::ST_CORNER};
    res_b   = '{corner_x: req.pos_x, corner_y: req.height, last_of_run: 1'b1,
                status: skyl_pkg::ST_CORNER};
    if (req.kind == skyl_pkg::KIND_START) begin
      if (full) begin
        res_cnt = 2'd1;
        res_a   = '{corner_x: req.pos_x, corner_y: req.height, last_of_run: 1'b1,
                    status: skyl_pkg::ST_FULL};
      end else if (req.height > old_max) begin
        res_cnt = 2'd2;
      end
    end else begin
      res_b.corner_y = new_max;
      if (!found) begin
        res_cnt = 2'd1;
        res_a   = '{corner_x: req.pos_x, corner_y: req.height, last_of_run: 1'b1,
                    status: skyl_pkg::ST_MISSING};
      end else if (new_max < old_max) begin
        res_cnt = 2'd2;
      end
    end
  end

  skyl_res_q u_res_q (
    .clk       (clk),
    .rst       (rst),
    .load      (busy),
    .load_cnt  (res_cnt),
    .load_a    (res_a),
    .load_b    (res_b),
    .crn_valid (crn_valid),
    .crn_ready (crn_ready),
    .crn       (crn),
    .level     (level)
  );

  // checks
  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    busy |-> (level == 2'd0))
    else $error("chain update while results still queued");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !evt_ready)
    else $error("event taken during chain update");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    (busy && (res_cnt != 2'd0)) |=> crn_valid)
    else $error("queued result not presented");

  for (genvar j = 0; j < MAX_ACTIVE - 1; j++) begin : g_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      row[j+1].vld |-> (row[j].vld && (row[j].hgt >= row[j+1].hgt)))
      else $error("height chain out of order");
  end

endmodule

FILE: verif/skyl_checker.sv
// checker for the skyline outline tracker: watches both channels, predicts and compares
// depends on skyl_pkg; instantiated beside the block by tb_skyline_outline_tracker
module skyl_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           evt_valid,
  input  logic           evt_ready,
  input  skyl_pkg::evt_t evt,
  input  logic           crn_valid,
  input  logic           crn_ready,
  input  skyl_pkg::crn_t crn,
  output int             n_fail,
  output int             n_pending,
  output int             n_events,
  output int             n_corner,
  output int             n_full,
  output int             n_missing
);

  localparam int DEPTH = skyl_pkg::MAX_ACTIVE_DEF;
  localparam int H_W   = skyl_pkg::H_W;
  localparam int X_W   = skyl_pkg::X_W;

  // predicted state of the active height table
  logic [H_W-1:0] level [DEPTH];
  bit             level_used [DEPTH];
  logic [H_W-1:0] top_level;
  int             n_active;

  // corners and status results still owed by the block
  skyl_pkg::crn_t corner_q [$];

  int fail_cnt;
  int event_cnt;
  int corner_cnt;
  int full_cnt;
  int missing_cnt;

  function automatic skyl_pkg::crn_t make_crn(input logic [X_W-1:0] x,
                                              input logic [H_W-1:0] y,
                                              input logic last,
                                              input logic [1:0] st);
    skyl_pkg::crn_t c;
    c.corner_x    = x;
    c.corner_y    = y;
    c.last_of_run = last;
    c.status      = st;
    return c;
  endfunction

  // queue one expected result at the tail
  task automatic add_result(input skyl_pkg::crn_t c);
    corner_q.insert(corner_q.size(), c);
  endtask

  // advance the predicted table by one edge request and queue what it causes
  task automatic apply_edge(input skyl_pkg::evt_t e);
    int             slot;
    logic [H_W-1:0] prev;
    logic [H_W-1:0] peak;
    slot = -1;
    if (e.kind == skyl_pkg::KIND_START) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (!level_used[i]) begin
          slot = i;
          break;
        end
      end
      if (slot < 0 || n_active >= DEPTH) begin
        add_result(make_crn(e.pos_x, e.height, 1'b1, skyl_pkg::ST_FULL));
        full_cnt++;
      end else begin
        level[slot]      = e.height;
        level_used[slot] = 1'b1;
        n_active++;
        // only a strictly higher start makes a step up
        if (e.height > top_level) begin
          add_result(make_crn(e.pos_x, top_level, 1'b0, skyl_pkg::ST_CORNER));
          add_result(make_crn(e.pos_x, e.height, 1'b1, skyl_pkg::ST_CORNER));
          corner_cnt += 2;
          top_level = e.height;
        end
      end
    end else begin
      // lowest used slot holding the height goes first
      for (int i = 0; i < DEPTH; i++) begin
        if (level_used[i] && level[i] == e.height) begin
          slot = i;
          break;
        end
      end
      if (slot < 0) begin
        add_result(make_crn(e.pos_x, e.height, 1'b1, skyl_pkg::ST_MISSING));
        missing_cnt++;
      end else begin
        level_used[slot] = 1'b0;
        if (n_active > 0) n_active--;
        prev = top_level;
        peak = '0;
        for (int i = 0; i < DEPTH; i++) begin
          if (level_used[i] && level[i] > peak) peak = level[i];
        end
        top_level = peak;
        if (peak < prev) begin
          add_result(make_crn(e.pos_x, prev, 1'b0, skyl_pkg::ST_CORNER));
          add_result(make_crn(e.pos_x, peak, 1'b1, skyl_pkg::ST_CORNER));
          corner_cnt += 2;
        end
      end
    end
  endtask

  // compare results before taking a new request, so a same-edge request cannot be matched
  always @(posedge clk) begin
    skyl_pkg::crn_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        level[i]      = '0;
        level_used[i] = 1'b0;
      end
      top_level = '0;
      n_active  = 0;
      corner_q.delete();
      fail_cnt    = 0;
      event_cnt   = 0;
      corner_cnt  = 0;
      full_cnt    = 0;
      missing_cnt = 0;
    end else begin
      if (crn_valid && crn_ready) begin
        if (corner_q.size() == 0) begin
          if (fail_cnt < 10)
            $display("unexpected result: x=%0d y=%0d last=%0d status=%0d",
                     crn.corner_x, crn.corner_y, crn.last_of_run, crn.status);
          fail_cnt++;
        end else begin
          want = corner_q.pop_front();
          if (crn.corner_x !== want.corner_x || crn.corner_y !== want.corner_y ||
              crn.last_of_run !== want.last_of_run || crn.status !== want.status) begin
            if (fail_cnt < 10)
              $display("mismatch: exp x=%0d y=%0d l=%0d s=%0d got x=%0d y=%0d l=%0d s=%0d",
                       want.corner_x, want.corner_y, want.last_of_run, want.status,
                       crn.corner_x, crn.corner_y, crn.last_of_run, crn.status);
            fail_cnt++;
          end
        end
      end
      if (evt_valid && evt_ready) begin
        apply_edge(evt);
        event_cnt++;
      end
    end
    n_fail    <= fail_cnt;
    n_pending <= corner_q.size();
    n_events  <= event_cnt;
    n_corner  <= corner_cnt;
    n_full    <= full_cnt;
    n_missing <= missing_cnt;
  end

endmodule

FILE: verif/tb_skyline_outline_tracker.sv
// testbench top for the skyline outline tracker: clock, reset, edge stimulus and verdict
// depends on skyl_pkg, skyline_outline_tracker and skyl_checker
module tb_skyline_outline_tracker;

  localparam int N_RANDOM = 1850;
  localparam int LIMIT    = 400000;
  localparam int H_W      = skyl_pkg::H_W;
  localparam int X_W      = skyl_pkg::X_W;

  logic clk;
  logic rst = 1'b1;
  logic evt_valid = 1'b0;
  logic evt_ready;
  skyl_pkg::evt_t evt = '0;
  logic crn_valid;
  logic crn_ready = 1'b0;
  skyl_pkg::crn_t crn;

  logic calm = 1'b0;
  logic hold_req = 1'b0;
  int   cycles = 0;

  int n_fail;
  int n_pending;
  int n_events;
  int n_corner;
  int n_full;
  int n_missing;

  skyline_outline_tracker DUT (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt),
    .crn_valid (crn_valid),
    .crn_ready (crn_ready),
    .crn       (crn)
  );

  skyl_checker CHK (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt),
    .crn_valid (crn_valid),
    .crn_ready (crn_ready),
    .crn       (crn),
    .n_fail    (n_fail),
    .n_pending (n_pending),
    .n_events  (n_events),
    .n_corner  (n_corner),
    .n_full    (n_full),
    .n_missing (n_missing)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic skyl_pkg::evt_t mk(input logic k, input logic [X_W-1:0] x,
                                        input logic [H_W-1:0] h);
    skyl_pkg::evt_t e;
    e.kind   = k;
    e.pos_x  = x;
    e.height = h;
    return e;
  endfunction

  // heights lean on a small range so duplicates and equal maxima turn up often
  function automatic logic [H_W-1:0] pick_height();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return '0;
    if (r < 14) return '1;
    if (r < 60) return H_W'($urandom_range(1, 24));
    return H_W'($urandom);
  endfunction

  // offer one request, with random idle cycles ahead of it
  task automatic push_evt(input skyl_pkg::evt_t e);
    while (!calm && $urandom_range(0, 99) < 28) begin
      evt_valid <= 1'b0;
      @(posedge clk);
    end
    evt_valid <= 1'b1;
    evt       <= e;
    @(posedge clk);
    while (!evt_ready) @(posedge clk);
  endtask

  // checker counts are registered, so look from the next edge on
  task automatic wait_drained();
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin : sink
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        crn_ready <= 1'b0;
        hold_done = 1'b1;
        repeat (300) @(posedge clk);
      end else begin
        crn_ready <= calm || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  // request side
  initial begin : stim
    skyl_pkg::evt_t e;
    logic [H_W-1:0] h;
    logic [X_W-1:0] x_run;
    logic [H_W-1:0] open_h [$];
    int             start_pct;
    int             pick;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: ground-level starts, equal maxima, duplicates, missing ends, field extremes
    push_evt(mk(skyl_pkg::KIND_START, 16'd0, 16'd0));
    push_evt(mk(skyl_pkg::KIND_START, 16'd0, 16'hFFFF));
    push_evt(mk(skyl_pkg::KIND_START, 16'd0, 16'hFFFF));
    push_evt(mk(skyl_pkg::KIND_END, 16'd1, 16'd100));
    push_evt(mk(skyl_pkg::KIND_END, 16'd2, 16'hFFFF));
    push_evt(mk(skyl_pkg::KIND_END, 16'd3, 16'hFFFF));
    push_evt(mk(skyl_pkg::KIND_END, 16'd4, 16'd0));
    push_evt(mk(skyl_pkg::KIND_END, 16'd5, 16'd0));
    push_evt(mk(skyl_pkg::KIND_START, 16'hFFFF, 16'd5));
    push_evt(mk(skyl_pkg::KIND_START, 16'hFFFF, 16'd3));
    push_evt(mk(skyl_pkg::KIND_START, 16'hFFFF, 16'd5));
    push_evt(mk(skyl_pkg::KIND_END, 16'hFFFF, 16'd5));
    push_evt(mk(skyl_pkg::KIND_END, 16'hFFFF, 16'd5));
    push_evt(mk(skyl_pkg::KIND_END, 16'hFFFF, 16'd3));
    push_evt(mk(skyl_pkg::KIND_START, 16'h5555, 16'h8000));
    push_evt(mk(skyl_pkg::KIND_START, 16'h5555, 16'h7FFF));
    push_evt(mk(skyl_pkg::KIND_END, 16'hAAAA, 16'h8000));
    push_evt(mk(skyl_pkg::KIND_END, 16'hAAAA, 16'h7FFF));
    push_evt(mk(skyl_pkg::KIND_END, 16'hAAAB, 16'hFFFF));

    // sender waits for every outstanding result
    evt_valid <= 1'b0;
    wait_drained();

    // random: buildings open and close in segments that fill, balance or drain the table
    x_run     = '0;
    start_pct = 50;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 150 == 0) begin
        case ($urandom_range(0, 2))
          0: start_pct = 50;
          1: start_pct = 80;
          default: start_pct = 30;
        endcase
        x_run = X_W'($urandom);
      end
      if (n == 400) hold_req <= 1'b1;
      if (n == 700) calm <= 1'b1;
      if (n == 950) calm <= 1'b0;
      if (n == 1200) begin
        evt_valid <= 1'b0;
        wait_drained();
      end
      x_run = x_run + X_W'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 8) begin
        // noise: end at an arbitrary place and height
        e = mk(skyl_pkg::KIND_END, X_W'($urandom), pick_height());
      end else if (open_h.size() == 0 ||
                   (open_h.size() < 72 && $urandom_range(0, 99) < start_pct)) begin
        h = pick_height();
        open_h.insert(open_h.size(), h);
        e = mk(skyl_pkg::KIND_START, x_run, h);
      end else begin
        pick = $urandom_range(0, open_h.size() - 1);
        h    = open_h[pick];
        open_h.delete(pick);
        e = mk(skyl_pkg::KIND_END, x_run, h);
      end
      push_evt(e);
    end

    evt_valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);

    $display("covered %0d edge requests: %0d corner results, %0d table-full, %0d missing-height",
             n_events, n_corner, n_full, n_missing);
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
